// ===== rtl/core/fircv_pkg.sv =====
// ----------------------------------------------------------------------------
// fircv_pkg
// Types and constants shared by the FIR convolution unit: sizes of the
// coefficient store and delay line, accumulator width, codes and states.
// ----------------------------------------------------------------------------
package fircv_pkg;

    localparam int MAX_TAPS    = 32;
    localparam int SAMPLE_BITS = 16;

    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int TAP_IDX_W = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
    localparam int ACC_W     = 2 * SAMPLE_BITS + $clog2(MAX_TAPS);

    localparam int COEF_IDX_W = 5;
    localparam int TAP_CFG_W  = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [0:0]           REG_TAP_COUNT   = 1'b0;
    localparam logic [TAP_CFG_W-1:0] TAP_COUNT_RESET = TAP_CFG_W'(32);

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMP_MAX  = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMP_MIN  = -(ACC_W'(1) <<< (SAMPLE_BITS - 1));

    typedef enum logic [0:0] {
        FUNC_LOAD_COEF   = 1'b0,
        FUNC_PUSH_SAMPLE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/core/fir_convolution_with_tails_unit.sv =====
// ----------------------------------------------------------------------------
// fir_convolution_with_tails_unit
// Direct-form FIR convolution with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A coefficient load beat gives no result and does not stall the input. A
// sample beat produces one output: tap_count (clamped to 1..MAX_TAPS) taps
// are multiply-accumulated in S_MAC, then S_EMIT rounds the sum and
// presents it once the output register is free. A sample marked last also
// produces taps-in-use minus one tail outputs, each with its own S_MAC and
// S_EMIT pass, and the last output of the stream carries o_last.
// The single multiplier and accumulator set the rate: one tap per cycle.
// Outputs are Q1.15, rounded half up and saturated, with o_saturated flagging
// a clipped value. The input stalls while a sample is in work; a finished
// output waits in its output register while the next beat is accepted.
// ----------------------------------------------------------------------------
module fir_convolution_with_tails_unit
    import fircv_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [COEF_IDX_W-1:0]         i_coef_index,
    input  logic signed [SAMPLE_BITS-1:0] i_value,
    input  logic                          i_last_sample,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_last,
    output logic                          o_saturated
);

    t_state                        r_state, n_state;
    logic [TAP_CFG_W-1:0]          r_tap_count;
    logic signed [SAMPLE_BITS-1:0] r_coef [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] n_coef [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_line [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] n_line [MAX_TAPS];
    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic [TAP_IDX_W-1:0]          r_j, n_j;
    logic [TAP_CNT_W-1:0]          r_taps, n_taps;
    logic [TAP_CNT_W-1:0]          r_tail, n_tail;
    logic                          r_last_in, n_last_in;
    logic                          r_ovalid, n_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_osample, n_osample;
    logic                          r_olast, n_olast;
    logic                          r_osat, n_osat;

    logic                          in_fire;
    logic                          out_free;
    logic                          cfg_wr;
    logic [TAP_CNT_W-1:0]          taps_use;
    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic signed [ACC_W-1:0]       rnd;
    logic signed [ACC_W-1:0]       shf;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2:2] == REG_TAP_COUNT);
    assign prdata = (paddr[2:2] == REG_TAP_COUNT)
                    ? APB_DATA_W'(r_tap_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RESET;
        end else if (cfg_wr) begin
            r_tap_count <= pwdata[TAP_CFG_W-1:0];
        end
    end

    always_comb begin
        if (r_tap_count == '0) begin
            taps_use = TAP_CNT_W'(1);
        end else if (int'(r_tap_count) > MAX_TAPS) begin
            taps_use = TAP_CNT_W'(MAX_TAPS);
        end else begin
            taps_use = TAP_CNT_W'(r_tap_count);
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign in_fire  = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign prod     = r_coef[r_j] * r_line[r_j];
    assign rnd      = r_acc + RND_HALF;
    assign shf      = rnd >>> FRAC_BITS;

    always_comb begin
        n_state   = r_state;
        n_coef    = r_coef;
        n_line    = r_line;
        n_acc     = r_acc;
        n_j       = r_j;
        n_taps    = r_taps;
        n_tail    = r_tail;
        n_last_in = r_last_in;
        n_ovalid  = r_ovalid;
        n_osample = r_osample;
        n_olast   = r_olast;
        n_osat    = r_osat;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_func == FUNC_LOAD_COEF) begin
                        if (int'(i_coef_index) < MAX_TAPS) begin
                            n_coef[TAP_IDX_W'(i_coef_index)] = i_value;
                        end
                    end else begin
                        for (int k = MAX_TAPS - 1; k > 0; k--) begin
                            n_line[k] = r_line[k-1];
                        end
                        n_line[0] = i_value;
                        n_taps    = taps_use;
                        n_tail    = i_last_sample ? (taps_use - TAP_CNT_W'(1)) : '0;
                        n_last_in = i_last_sample;
                        n_j       = '0;
                        n_acc     = '0;
                        n_state   = S_MAC;
                    end
                end
            end
            S_MAC: begin
                n_acc = r_acc + ACC_W'(prod);
                if (TAP_CNT_W'(r_j) == r_taps - TAP_CNT_W'(1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_j = r_j + TAP_IDX_W'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_olast  = r_last_in && (r_tail == '0);
                    if (shf > SMP_MAX) begin
                        n_osample = SMP_MAX[SAMPLE_BITS-1:0];
                        n_osat    = 1'b1;
                    end else if (shf < SMP_MIN) begin
                        n_osample = SMP_MIN[SAMPLE_BITS-1:0];
                        n_osat    = 1'b1;
                    end else begin
                        n_osample = shf[SAMPLE_BITS-1:0];
                        n_osat    = 1'b0;
                    end
                    if (r_tail != '0) begin
                        for (int k = MAX_TAPS - 1; k > 0; k--) begin
                            n_line[k] = r_line[k-1];
                        end
                        n_line[0] = '0;
                        n_tail    = r_tail - TAP_CNT_W'(1);
                        n_j       = '0;
                        n_acc     = '0;
                        n_state   = S_MAC;
                    end else begin
                        if (r_last_in) begin
                            for (int k = 0; k < MAX_TAPS; k++) begin
                                n_line[k] = '0;
                            end
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_j      <= '0;
            r_taps   <= TAP_CNT_W'(1);
            r_tail   <= '0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_coef[k] <= '0;
                r_line[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_j      <= n_j;
            r_taps   <= n_taps;
            r_tail   <= n_tail;
            r_coef   <= n_coef;
            r_line   <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_last_in <= n_last_in;
        r_osample <= n_osample;
        r_olast   <= n_olast;
        r_osat    <= n_osat;
    end

    assign o_valid      = r_ovalid;
    assign o_out_sample = r_osample;
    assign o_last       = r_olast;
    assign o_saturated  = r_osat;

`ifndef SYNTHESIS
    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (TAP_CNT_W'(r_j) < r_taps))
        else $error("MAC tap index beyond the taps in use");

    a_tail_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_tail < r_taps))
        else $error("tail count exceeds taps in use minus one");

    a_sample_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_func == FUNC_PUSH_SAMPLE)) |=> (r_state == S_MAC))
        else $error("accepted sample beat did not start accumulation");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && r_ovalid && i_stall) |=> (r_state == S_EMIT))
        else $error("result left emit while output register was full");
`endif

endmodule

// ===== dv/fir_convolution_with_tails_unit_test.sv =====
// ----------------------------------------------------------------------------
// fir_convolution_with_tails_unit_test
// Self-checking testbench for the FIR convolution unit. It loads coefficients
// and pushes sample streams through the beat channel and programs tap_count
// over APB. A local model of the coefficient store and delay line predicts
// every output, tail outputs included. A checker compares each output beat
// with the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module fir_convolution_with_tails_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fircv_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          last;
        logic                          sat;
    } t_conv_result;

    localparam logic [APB_ADDR_W-1:0] TAP_ADDR  = APB_ADDR_W'(4 * REG_TAP_COUNT);
    localparam longint                RUN_LIMIT = 64'd60_000_000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [APB_ADDR_W-1:0]         paddr;
    logic [APB_DATA_W-1:0]         pwdata;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_func;
    logic [COEF_IDX_W-1:0]         i_coef_index;
    logic signed [SAMPLE_BITS-1:0] i_value;
    logic                          i_last_sample;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [SAMPLE_BITS-1:0] o_out_sample;
    logic                          o_last;
    logic                          o_saturated;

    logic signed [SAMPLE_BITS-1:0] coef_mirror    [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] history_mirror [MAX_TAPS-1];
    logic [TAP_CFG_W-1:0]          tap_cfg_mirror;
    t_conv_result                  expected_outputs [$];

    int mismatch_count = 0;
    int beats_sent     = 0;
    int hold_cycles    = 0;
    bit idle_on        = 1'b1;

    fir_convolution_with_tails_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_coef_index  (i_coef_index),
        .i_value       (i_value),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_sample  (o_out_sample),
        .o_last        (o_last),
        .o_saturated   (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void flag_error(input string msg);
        if (mismatch_count < 10) begin
            $display("%s", msg);
        end
        mismatch_count++;
    endfunction

    function automatic int taps_in_use();
        if (tap_cfg_mirror == 0) begin
            return 1;
        end
        if (tap_cfg_mirror > MAX_TAPS) begin
            return MAX_TAPS;
        end
        return int'(tap_cfg_mirror);
    endfunction

    // Shifts x into the delay line and queues the rounded, saturated output.
    function automatic void emit_output(input logic signed [SAMPLE_BITS-1:0] x,
                                        input int taps, input logic is_last);
        longint       acc;
        longint       rounded;
        longint       smp_max;
        longint       smp_min;
        int           j;
        t_conv_result r;
        smp_max = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        smp_min = -(longint'(1) <<< (SAMPLE_BITS - 1));
        acc = longint'(coef_mirror[0]) * longint'(x);
        for (j = 1; j < taps; j++) begin
            acc += longint'(coef_mirror[j]) * longint'(history_mirror[j-1]);
        end
        for (j = MAX_TAPS - 2; j > 0; j--) begin
            history_mirror[j] = history_mirror[j-1];
        end
        history_mirror[0] = x;
        rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r.sat = 1'b0;
        if (rounded > smp_max) begin
            rounded = smp_max;
            r.sat = 1'b1;
        end else if (rounded < smp_min) begin
            rounded = smp_min;
            r.sat = 1'b1;
        end
        r.smp  = rounded[SAMPLE_BITS-1:0];
        r.last = is_last;
        expected_outputs.push_back(r);
    endfunction

    function automatic void predict_push(input logic signed [SAMPLE_BITS-1:0] x,
                                         input logic last_in);
        int taps;
        int t;
        taps = taps_in_use();
        emit_output(x, taps, last_in && taps == 1);
        if (last_in) begin
            for (t = 1; t < taps; t++) begin
                emit_output('0, taps, t == taps - 1);
            end
            for (t = 0; t < MAX_TAPS - 1; t++) begin
                history_mirror[t] = '0;
            end
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return SAMPLE_BITS'($signed($urandom_range(0, 1023)) - 512);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_beat(input t_func f, input logic [COEF_IDX_W-1:0] idx,
                             input logic signed [SAMPLE_BITS-1:0] val, input logic lst);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_func        = f;
        i_coef_index  = idx;
        i_value       = val;
        i_last_sample = lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (f == FUNC_LOAD_COEF) begin
            coef_mirror[idx] = val;
        end else begin
            predict_push(val, lst);
        end
        beats_sent++;
    endtask

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] val, input logic lst);
        send_beat(FUNC_PUSH_SAMPLE, COEF_IDX_W'($urandom), val, lst);
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (MAX_TAPS + 8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == TAP_ADDR) begin
            tap_cfg_mirror = data[TAP_CFG_W-1:0];
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check_tap_count();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = TAP_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[TAP_CFG_W-1:0] !== tap_cfg_mirror) begin
            flag_error($sformatf("tap_count read: expected %0d, got %0d",
                                 tap_cfg_mirror, prdata[TAP_CFG_W-1:0]));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure_taps(input int taps_req);
        drain_and_settle();
        apb_write(TAP_ADDR, APB_DATA_W'(taps_req));
    endtask

    task automatic test_register_access();
        apb_check_tap_count();
        apb_write(TAP_ADDR, APB_DATA_W'(63));
        apb_check_tap_count();
        apb_write(TAP_ADDR, APB_DATA_W'(0));
        apb_check_tap_count();
    endtask

    task automatic test_directed();
        configure_taps(4);
        send_beat(FUNC_LOAD_COEF, COEF_IDX_W'(0), 16'sh8000, 1'b0);
        send_beat(FUNC_LOAD_COEF, COEF_IDX_W'(1), 16'sh8000, 1'b0);
        send_beat(FUNC_LOAD_COEF, COEF_IDX_W'(2), 16'sh7FFF, 1'b0);
        send_beat(FUNC_LOAD_COEF, COEF_IDX_W'(3), 16'sh0001, 1'b0);
        // An index beyond tap_count is kept, and last_sample on a load does nothing.
        send_beat(FUNC_LOAD_COEF, COEF_IDX_W'(MAX_TAPS - 1), 16'sd12345, 1'b1);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b1);
        configure_taps(0);
        push_sample(16'sd100, 1'b1);
        push_sample(16'sh8000, 1'b0);
        configure_taps(63);
        push_sample(16'sh7FFF, 1'b1);
        configure_taps(1);
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd1, 1'b1);
    endtask

    task automatic test_random_streams();
        int start_beats;
        int taps_req;
        int eff;
        int n_coef;
        int n_streams;
        int len;
        int s;
        int k;
        bit broken;
        start_beats = beats_sent;
        while (beats_sent - start_beats < 300) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 11))
                0:       taps_req = MAX_TAPS;
                1:       taps_req = $urandom_range(MAX_TAPS + 1, 63);
                2:       taps_req = 0;
                default: taps_req = $urandom_range(1, 8);
            endcase
            configure_taps(taps_req);
            eff = taps_in_use();
            if ($urandom_range(0, 4) == 0) begin
                n_coef = MAX_TAPS;
            end else begin
                n_coef = eff + $urandom_range(0, 2);
                if (n_coef > MAX_TAPS) begin
                    n_coef = MAX_TAPS;
                end
            end
            for (k = 0; k < n_coef; k++) begin
                send_beat(FUNC_LOAD_COEF, COEF_IDX_W'(k), rand_value(), 1'($urandom));
            end
            n_streams = $urandom_range(1, 3);
            for (s = 0; s < n_streams; s++) begin
                len    = (eff > 8) ? $urandom_range(1, 5) : $urandom_range(1, 24);
                broken = ($urandom_range(0, 7) == 0);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_beat(FUNC_LOAD_COEF, COEF_IDX_W'($urandom), rand_value(),
                                  1'($urandom));
                    end
                    push_sample(rand_value(), k == len - 1 && !broken);
                end
            end
        end
    endtask

    task automatic test_backpressure();
        int k;
        idle_on = 1'b1;
        configure_taps(3);
        for (k = 0; k < 3; k++) begin
            send_beat(FUNC_LOAD_COEF, COEF_IDX_W'(k), rand_value(), 1'b0);
        end
        hold_cycles = 400;
        for (k = 0; k < 16; k++) begin
            push_sample(rand_value(), k % 5 == 4);
        end
        drain_and_settle();
        for (k = 0; k < 4; k++) begin
            push_sample(rand_value(), k == 3);
        end
    endtask

    task automatic test_quiet_tail();
        int k;
        idle_on = 1'b0;
        configure_taps(5);
        for (k = 0; k < 5; k++) begin
            send_beat(FUNC_LOAD_COEF, COEF_IDX_W'(k), rand_value(), 1'b0);
        end
        for (k = 0; k < 30; k++) begin
            push_sample(rand_value(), k == 14 || k == 29);
        end
    endtask

    // Receiver side: random stall bursts, plus one long hold when requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                i_stall = 1'b1;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
                i_stall     = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_stall = 1'b0;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_outputs
        t_conv_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_outputs.size() == 0) begin
                flag_error($sformatf("unexpected output beat: sample %0d last %0b sat %0b",
                                     o_out_sample, o_last, o_saturated));
            end else begin
                want = expected_outputs.pop_front();
                if (o_out_sample !== want.smp || o_last !== want.last
                        || o_saturated !== want.sat) begin
                    flag_error($sformatf(
                        "output mismatch (exp/act): sample %0d/%0d last %0b/%0b sat %0b/%0b",
                        want.smp, o_out_sample, want.last, o_last, want.sat, o_saturated));
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int t;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_func        = FUNC_LOAD_COEF;
        i_coef_index  = '0;
        i_value       = '0;
        i_last_sample = 1'b0;
        i_stall       = 1'b0;
        tap_cfg_mirror = TAP_COUNT_RESET;
        for (t = 0; t < MAX_TAPS; t++) begin
            coef_mirror[t] = '0;
        end
        for (t = 0; t < MAX_TAPS - 1; t++) begin
            history_mirror[t] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_access();
        test_directed();
        test_random_streams();
        test_backpressure();
        test_quiet_tail();

        drain_and_settle();
        if (mismatch_count == 0 && expected_outputs.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
